/* design/scds_pkg.sv */
// Shared constants, types and sizing functions for the serial clock divider search.
package scds_pkg;

  localparam int PRESCALE_LIMIT_DEF = 255;
  localparam int RATE_MAX_DEF       = 255;

  localparam logic [31:0] CLOCK_FREQ_RESET = 32'd125000000;

  // Steps of the bit-serial clock_freq / bit_rate divider
  localparam int MAIN_DIV_STEPS = 32;
  // Quotient bits retired per step of the prescale trial divider
  localparam int SRCH_RADIX_BITS = 4;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       srch_start;
    logic       srch_step;
    logic       next_p;
    logic       set_res;
    logic [1:0] res_code;
  } scds_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic div_skip;
    logic hit;
    logic p_last;
  } scds_stat_t;

  // Largest divisor product prescale * (1 + rate) reachable
  function automatic int scds_vmax(int plim, int rmax);
    return ((plim - 1) / 2) * 2 * (rmax + 1);
  endfunction

  // Bits to hold divider + 1 for every divider that can still match
  function automatic int scds_div_w(int plim, int rmax);
    return $clog2(scds_vmax(plim, rmax) + 3);
  endfunction

  function automatic int scds_srch_steps(int plim, int rmax);
    return (scds_div_w(plim, rmax) + SRCH_RADIX_BITS - 1) / SRCH_RADIX_BITS;
  endfunction

endpackage

/* design/scds_ctrl.sv */
// Sequencer for the divider search: division, per-prescale trials, result hand-off.
module scds_ctrl
  import scds_pkg::*;
#(
  parameter int SRCH_STEPS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  scds_stat_t stat,
  output scds_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [4:0] MAIN_LAST = 5'(MAIN_DIV_STEPS - 1);
  localparam logic [4:0] SRCH_LAST = 5'(SRCH_STEPS - 1);

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] code_r, code_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == MAIN_LAST) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_CHECK: begin
        priority if (stat.rate_zero) begin
          code_nxt  = STATUS_INVALID;
          state_nxt = S_OUT;
        end else if (stat.div_skip) begin
          code_nxt  = STATUS_NO_MATCH;
          state_nxt = S_OUT;
        end else begin
          cmd.srch_start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (cnt_r == SRCH_LAST) begin
          state_nxt = S_TEST;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_TEST: begin
        priority if (stat.hit) begin
          code_nxt  = STATUS_FOUND;
          state_nxt = S_OUT;
        end else if (stat.p_last) begin
          code_nxt  = STATUS_NO_MATCH;
          state_nxt = S_OUT;
        end else begin
          cmd.next_p = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_SRCH;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.set_res   = 1'b1;
          cmd.res_code  = code_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      code_r      <= STATUS_NO_MATCH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/scds_dp.sv */
// Datapath: clock register, serial divider, prescale trial divider and result register.
module scds_dp
  import scds_pkg::*;
#(
  parameter int PRESCALE_LIMIT = PRESCALE_LIMIT_DEF,
  parameter int RATE_MAX       = RATE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [31:0] in_bit_rate,
  input  scds_cmd_t   cmd,
  output scds_stat_t  stat,
  output logic [1:0]  out_status,
  output logic [7:0]  out_prescale,
  output logic [7:0]  out_serial_rate
);

  localparam int PW  = $clog2(PRESCALE_LIMIT);
  localparam int DW  = scds_div_w(PRESCALE_LIMIT, RATE_MAX);
  localparam int SNW = SRCH_RADIX_BITS * scds_srch_steps(PRESCALE_LIMIT, RATE_MAX);

  localparam logic [31:0]    DIV_MAX = 32'(scds_vmax(PRESCALE_LIMIT, RATE_MAX) + 1);
  localparam logic [PW:0]    P_LIM   = (PW + 1)'(PRESCALE_LIMIT);
  localparam logic [SNW-1:0] K_MAX   = SNW'(RATE_MAX + 1);

  logic [31:0]    clock_freq_r;
  logic [31:0]    den_r;
  logic [31:0]    num_r;
  logic [31:0]    rem_r;
  logic [DW-1:0]  n_r;
  logic [PW-1:0]  p_r;
  logic [SNW-1:0] sn_r;
  logic [PW-1:0]  srem_r;
  logic [1:0]     status_r;
  logic [7:0]     prescale_r;
  logic [7:0]     rate_r;

  // one restoring step of clock_freq / bit_rate
  logic [32:0] main_t;
  logic [32:0] main_d;
  logic        main_ge;
  assign main_t  = {rem_r, num_r[31]};
  assign main_d  = main_t - {1'b0, den_r};
  assign main_ge = main_t >= {1'b0, den_r};

  logic [DW-1:0] n_calc;
  assign n_calc = num_r[DW-1:0] + DW'(1);

  // four restoring steps of (divider + 1) / prescale
  logic [SNW-1:0] sn_step;
  logic [PW-1:0]  srem_step;
  always_comb begin
    logic [PW:0]    t;
    logic [PW-1:0]  r;
    logic [SNW-1:0] n;
    r = srem_r;
    n = sn_r;
    for (int i = 0; i < SRCH_RADIX_BITS; i++) begin
      t = {r, n[SNW-1]};
      n = {n[SNW-2:0], 1'b0};
      if (t >= {1'b0, p_r}) begin
        t    = t - {1'b0, p_r};
        n[0] = 1'b1;
      end
      r = t[PW-1:0];
    end
    sn_step   = n;
    srem_step = r;
  end

  // smallest multiple of the prescale inside the window around the divider
  logic [SNW-1:0] k;
  logic [SNW-1:0] k_m1;
  assign k    = (srem_r == '0 && p_r == PW'(2)) ? sn_r - SNW'(1) : sn_r;
  assign k_m1 = k - SNW'(1);

  assign stat.rate_zero = den_r == '0;
  assign stat.div_skip  = (num_r < 32'd2) || (num_r > DIV_MAX);
  assign stat.hit       = (srem_r <= PW'(2)) && (k <= K_MAX);
  assign stat.p_last    = ({1'b0, p_r} + (PW + 1)'(2)) >= P_LIM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_freq_r <= CLOCK_FREQ_RESET;
    end else if (cfg_wr_en) begin
      clock_freq_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r <= in_bit_rate;
      num_r <= clock_freq_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[30:0], main_ge};
      rem_r <= main_ge ? main_d[31:0] : main_t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      n_r    <= n_calc;
      p_r    <= PW'(2);
      sn_r   <= SNW'(n_calc);
      srem_r <= '0;
    end else if (cmd.next_p) begin
      p_r    <= p_r + PW'(2);
      sn_r   <= SNW'(n_r);
      srem_r <= '0;
    end else if (cmd.srch_step) begin
      sn_r   <= sn_step;
      srem_r <= srem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      status_r <= cmd.res_code;
      if (cmd.res_code == STATUS_FOUND) begin
        prescale_r <= 8'(p_r);
        rate_r     <= 8'(k_m1);
      end else begin
        prescale_r <= '0;
        rate_r     <= '0;
      end
    end
  end

  assign out_status      = status_r;
  assign out_prescale    = prescale_r;
  assign out_serial_rate = rate_r;

endmodule

/* design/spi_clock_divider_search_top.sv */
// Serial port clock divider search: finds prescale and rate for a requested bit rate.
//
// Input channel in_*: one transfer carries a requested bit rate. Result channel out_*:
// one transfer per request with status, prescale and serial rate. cfg_wr_en writes the
// peripheral clock frequency; write it only while no request is in flight.
// A request is taken only while the block is free. The divider clock_freq / bit_rate
// runs one quotient bit a cycle; each even prescale is then tried by a
// radix-16 trial divider. The next request is taken the cycle after the
// result is loaded into the output register.
// Reset restores the clock frequency to 125 MHz and drops any request in flight.
// When the receiver stalls, the result holds in the output register; a new request
// is still accepted and computed, and its result waits until the register frees.
module spi_clock_divider_search_top
  import scds_pkg::*;
#(
  parameter int PRESCALE_LIMIT = PRESCALE_LIMIT_DEF,
  parameter int RATE_MAX       = RATE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] bit_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [9:2] prescale, [17:10] serial_rate
);

  localparam int SRCH_STEPS = scds_srch_steps(PRESCALE_LIMIT, RATE_MAX);

  scds_cmd_t  cmd;
  scds_stat_t stat;
  logic [1:0] status;
  logic [7:0] prescale;
  logic [7:0] serial_rate;

  scds_ctrl #(
    .SRCH_STEPS(SRCH_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scds_dp #(
    .PRESCALE_LIMIT(PRESCALE_LIMIT),
    .RATE_MAX      (RATE_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_bit_rate    (in_tdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (status),
    .out_prescale   (prescale),
    .out_serial_rate(serial_rate)
  );

  assign out_tdata = {6'b0, serial_rate, prescale, status};

endmodule

/* design/scds_checker.sv */
// Port-level checks for the divider search block, bound to the top level.
module scds_checker
  import scds_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // one request at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one still in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == STATUS_FOUND || out_tdata[1:0] == STATUS_INVALID ||
                    out_tdata[1:0] == STATUS_NO_MATCH))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STATUS_FOUND |-> out_tdata[17:2] == 16'd0)
    else $error("nonzero divider fields on failed search");

  a_found_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STATUS_FOUND |-> !out_tdata[2] && out_tdata[9:2] != 8'd0)
    else $error("found prescale is zero or odd");

endmodule

bind spi_clock_divider_search_top scds_checker u_scds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
